// ----- hdl/xcfp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XOR checked frame parser package
// Shared widths and the result type passed between the parser and the
// output stage.
// ----------------------------------------------------------------------------
package xcfp_pkg;

    localparam int BYTE_W    = 8;
    localparam int LENGTH_W  = 4;
    localparam int PAYLOAD_W = 64;

    typedef struct packed {
        logic [BYTE_W-1:0]    command;
        logic [LENGTH_W-1:0]  payload_length;
        logic [PAYLOAD_W-1:0] payload;
        logic                 checksum_ok;
    } t_result;

endpackage

// ----- hdl/xcfp_parse.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame parser state machine
// Tracks the frame phase, running XOR and payload bytes, and builds the
// result on the checksum beat.
// ----------------------------------------------------------------------------
module xcfp_parse
    import xcfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [BYTE_W-1:0] i_cfg_header_byte,
    input  wire logic              i_beat,
    input  wire logic [BYTE_W-1:0] i_rx_byte,
    output logic                   o_res_valid,
    output t_result                o_res
);

    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_COMMAND = 3'd1;
    localparam logic [2:0] PH_LENGTH  = 3'd2;
    localparam logic [2:0] PH_DATA    = 3'd3;
    localparam logic [2:0] PH_CHECK   = 3'd4;

    logic [BYTE_W-1:0]   r_header_byte;
    logic [2:0]          r_phase, n_phase;
    logic [BYTE_W-1:0]   r_xor, n_xor;
    logic [BYTE_W-1:0]   r_command, n_command;
    logic [LENGTH_W-1:0] r_length, n_length;
    logic [LENGTH_W-1:0] r_count, n_count;
    logic [BYTE_W-1:0]   r_store [MAX_PAYLOAD];
    logic                store_we;
    logic [LENGTH_W-1:0] count_inc;
    logic [PAYLOAD_W-1:0] packed_payload;

    assign count_inc = r_count + LENGTH_W'(1);

    always_comb begin
        n_phase   = r_phase;
        n_xor     = r_xor;
        n_command = r_command;
        n_length  = r_length;
        n_count   = r_count;
        store_we  = 1'b0;
        unique case (r_phase)
            PH_HEADER: begin
                if (i_rx_byte == r_header_byte) begin
                    n_xor   = i_rx_byte;
                    n_count = '0;
                    n_phase = PH_COMMAND;
                end
            end
            PH_COMMAND: begin
                n_command = i_rx_byte;
                n_xor     = r_xor ^ i_rx_byte;
                n_phase   = PH_LENGTH;
            end
            PH_LENGTH: begin
                if (i_rx_byte > BYTE_W'(MAX_PAYLOAD)) begin
                    n_phase = PH_HEADER;
                end else begin
                    n_length = i_rx_byte[LENGTH_W-1:0];
                    n_xor    = r_xor ^ i_rx_byte;
                    n_count  = '0;
                    n_phase  = (i_rx_byte == '0) ? PH_CHECK : PH_DATA;
                end
            end
            PH_DATA: begin
                store_we = 1'b1;
                n_xor    = r_xor ^ i_rx_byte;
                n_count  = count_inc;
                if (count_inc >= r_length) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                n_phase = PH_HEADER;
            end
            default: begin
                n_phase = PH_HEADER;
            end
        endcase
    end

    always_comb begin
        packed_payload = '0;
        for (int k = 0; k < MAX_PAYLOAD; k++) begin
            if (LENGTH_W'(k) < r_length) begin
                packed_payload[k*BYTE_W +: BYTE_W] = r_store[k];
            end
        end
    end

    assign o_res_valid          = i_beat && (r_phase == PH_CHECK);
    assign o_res.command        = r_command;
    assign o_res.payload_length = r_length;
    assign o_res.payload        = packed_payload;
    assign o_res.checksum_ok    = (r_xor == i_rx_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_byte <= 8'd170;
            r_phase       <= PH_HEADER;
            r_xor         <= '0;
            r_command     <= '0;
            r_length      <= '0;
            r_count       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_header_byte <= i_cfg_header_byte;
            end
            if (i_beat) begin
                r_phase   <= n_phase;
                r_xor     <= n_xor;
                r_command <= n_command;
                r_length  <= n_length;
                r_count   <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_beat && store_we) begin
            r_store[r_count[IDX_W-1:0]] <= i_rx_byte;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/xcfp_out_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result output stage
// Output register with a skid entry, so the parser keeps taking beats while
// a finished result waits downstream.
// ----------------------------------------------------------------------------
module xcfp_out_stage
    import xcfp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_res_valid,
    input  wire t_result i_res,
    output logic         o_valid,
    output t_result      o_res,
    input  wire logic    i_stall,
    output logic         o_full
);

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;
    logic    out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= i_res_valid;
                end
            end else if (i_res_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_res_valid) begin
                r_out <= i_res;
            end
        end else if (i_res_valid) begin
            r_skid <= i_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign o_full  = r_skid_valid;

endmodule
`default_nettype wire

// ----- hdl/xor_checked_frame_parser_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XOR checked frame parser core
// Hunts for a header byte, reads command, length, payload and checksum bytes, and
// delivers one result per frame of length up to MAX_PAYLOAD with an XOR checksum flag.
//
//   Channel   Direction  Handshake            Payload
//   in        input      i_in_valid/o_in_stall  i_rx_byte
//   out       output     o_out_valid/i_out_stall  command, length, payload, ok
//   cfg       input      i_cfg_valid/o_cfg_ready  i_cfg_header_byte
//
// One byte is taken per cycle while o_in_stall is low; parser state updates on each taken byte.
// Each result is registered in the output register, or in the skid entry when that is held.
// Input stalls only when both the output register and skid entry are full.
// Reset is synchronous and leaves the parser hunting for header byte 170.
// ----------------------------------------------------------------------------
module xor_checked_frame_parser_core
    import xcfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [BYTE_W-1:0]    i_rx_byte,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [BYTE_W-1:0]         o_command,
    output logic [LENGTH_W-1:0]       o_payload_length,
    output logic [PAYLOAD_W-1:0]      o_payload,
    output logic                      o_checksum_ok,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [BYTE_W-1:0]    i_cfg_header_byte
);

    logic    beat;
    logic    res_valid;
    t_result res;
    t_result out_res;
    logic    out_full;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = out_full;
    assign beat        = i_in_valid && !out_full;

    xcfp_parse #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parse (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_header_byte (i_cfg_header_byte),
        .i_beat            (beat),
        .i_rx_byte         (i_rx_byte),
        .o_res_valid       (res_valid),
        .o_res             (res)
    );

    xcfp_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_valid     (o_out_valid),
        .o_res       (out_res),
        .i_stall     (i_out_stall),
        .o_full      (out_full)
    );

    assign o_command        = out_res.command;
    assign o_payload_length = out_res.payload_length;
    assign o_payload        = out_res.payload;
    assign o_checksum_ok    = out_res.checksum_ok;

endmodule
`default_nettype wire

// ----- bench/xor_checked_frame_parser_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XOR checked frame parser core testbench
// Drives a byte stream into the parser: first a short scripted stream of
// frames, then random frames under several header settings. A behavioral
// predictor tracks the frame state and the checksum. Every result beat is
// checked against the scripted or predicted frame. The sender runs in
// bursts, and the result side stalls on its own pattern.
// ----------------------------------------------------------------------------
module xor_checked_frame_parser_core_test;
    import xcfp_pkg::*;

    localparam int MAX_PAYLOAD   = 8;
    localparam int PHASE_ITEMS   = 350;
    localparam int LATENCY_SLACK = 8;
    localparam int CYCLE_LIMIT   = 400000;

    typedef enum logic [2:0] {
        HUNT         = 3'd0,
        GET_COMMAND  = 3'd1,
        GET_LENGTH   = 3'd2,
        GET_PAYLOAD  = 3'd3,
        GET_CHECKSUM = 3'd4
    } t_frame_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] rx;
        logic              has_want;
        t_result           want;
    } t_script_row;

    localparam t_script_row DIRECTED [25] = '{
        '{8'hAA, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'hAA, 1'b1, '{8'h00, 4'd0, 64'h0, 1'b1}},
        '{8'h55, 1'b0, '0},
        '{8'hAA, 1'b0, '0},
        '{8'h12, 1'b0, '0},
        '{8'h09, 1'b0, '0},
        '{8'hAA, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h08, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{8'h02, 1'b0, '0},
        '{8'h03, 1'b0, '0},
        '{8'h04, 1'b0, '0},
        '{8'h05, 1'b0, '0},
        '{8'h06, 1'b0, '0},
        '{8'h07, 1'b0, '0},
        '{8'h08, 1'b0, '0},
        '{8'h55, 1'b1, '{8'hFF, 4'd8, 64'h0807060504030201, 1'b1}},
        '{8'hAA, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b1, '{8'h01, 4'd1, 64'hFF, 1'b0}}
    };

    logic                  i_clk             = 1'b0;
    logic                  i_rst_n           = 1'b0;
    logic                  i_in_valid        = 1'b0;
    logic                  o_in_stall;
    logic [BYTE_W-1:0]     i_rx_byte         = '0;
    logic                  o_out_valid;
    logic                  i_out_stall       = 1'b0;
    logic [BYTE_W-1:0]     o_command;
    logic [LENGTH_W-1:0]   o_payload_length;
    logic [PAYLOAD_W-1:0]  o_payload;
    logic                  o_checksum_ok;
    logic                  i_cfg_valid       = 1'b0;
    logic                  o_cfg_ready;
    logic [BYTE_W-1:0]     i_cfg_header_byte = '0;

    t_frame_phase          rx_phase;
    logic [BYTE_W-1:0]     frame_header;
    logic [BYTE_W-1:0]     frame_xor;
    logic [BYTE_W-1:0]     frame_command;
    logic [LENGTH_W-1:0]   frame_length;
    logic [LENGTH_W-1:0]   payload_count;
    logic [PAYLOAD_W-1:0]  payload_bytes;

    t_result               expected_frames [$];
    t_result               oldest_frame;
    int                    errors       = 0;
    int                    cycle_count  = 0;
    int                    items_sent   = 0;
    int                    burst_left   = 0;
    bit                    in_lowered   = 1'b1;
    int                    stall_mode   = 0;
    int                    mode_left    = 0;
    int                    stall_run    = 0;

    xor_checked_frame_parser_core #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_command        (o_command),
        .o_payload_length (o_payload_length),
        .o_payload        (o_payload),
        .o_checksum_ok    (o_checksum_ok),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_header_byte(i_cfg_header_byte)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_frame_state();
        frame_header  = 8'd170;
        rx_phase      = HUNT;
        frame_xor     = '0;
        frame_command = '0;
        frame_length  = '0;
        payload_count = '0;
        payload_bytes = '0;
    endfunction

    function automatic bit parse_byte(input logic [BYTE_W-1:0] b, output t_result res);
        int k;
        parse_byte = 1'b0;
        res = '0;
        case (rx_phase)
            HUNT: begin
                if (b == frame_header) begin
                    frame_xor     = b;
                    payload_count = '0;
                    payload_bytes = '0;
                    rx_phase      = GET_COMMAND;
                end
            end
            GET_COMMAND: begin
                frame_command = b;
                frame_xor     = frame_xor ^ b;
                rx_phase      = GET_LENGTH;
            end
            GET_LENGTH: begin
                if (b > MAX_PAYLOAD) begin
                    rx_phase = HUNT;
                end else begin
                    frame_length  = b[LENGTH_W-1:0];
                    frame_xor     = frame_xor ^ b;
                    payload_count = '0;
                    rx_phase      = (b == 8'd0) ? GET_CHECKSUM : GET_PAYLOAD;
                end
            end
            GET_PAYLOAD: begin
                payload_bytes[8*payload_count[2:0] +: 8] = b;
                frame_xor     = frame_xor ^ b;
                payload_count = payload_count + 4'd1;
                if (payload_count >= frame_length) rx_phase = GET_CHECKSUM;
            end
            GET_CHECKSUM: begin
                res.command        = frame_command;
                res.payload_length = frame_length;
                for (k = 0; k < 8; k++) begin
                    if (k < frame_length) res.payload[8*k +: 8] = payload_bytes[8*k +: 8];
                end
                res.checksum_ok = (frame_xor == b);
                rx_phase        = HUNT;
                parse_byte      = 1'b1;
            end
            default: begin
                rx_phase = HUNT;
            end
        endcase
    endfunction

    // The expectation is queued at the accepting edge, before any gap, so that
    // a result beat can never arrive ahead of its prediction.
    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic has_want,
                             input t_result want);
        t_result res;
        bit      produced;
        int      gap;
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        in_lowered = 1'b0;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        produced = parse_byte(b, res);
        if (has_want) expected_frames.push_back(want);
        else if (produced) expected_frames.push_back(res);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                in_lowered = 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic drain_results();
        if (!in_lowered) begin
            i_in_valid <= 1'b0;
            in_lowered = 1'b1;
        end
        while (expected_frames.size() != 0) @(posedge i_clk);
        repeat (LATENCY_SLACK) @(posedge i_clk);
    endtask

    task automatic write_header(input logic [BYTE_W-1:0] h);
        drain_results();
        i_cfg_valid       <= 1'b1;
        i_cfg_header_byte <= h;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid  <= 1'b0;
        frame_header = h;
    endtask

    // Mostly well-formed frames with random content; some noise, oversize
    // lengths, bad checksums and frames cut short.
    task automatic send_random_frame();
        logic [BYTE_W-1:0] fq [$];
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] lenb;
        int                sel;
        int                cut;
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        end
        sel = $urandom_range(0, 15);
        if (sel < 2) lenb = 8'd0;
        else if (sel < 4) lenb = 8'd8;
        else if (sel < 14) lenb = 8'($urandom_range(1, 7));
        else if (sel == 14) lenb = 8'($urandom_range(9, 15));
        else lenb = 8'($urandom_range(16, 255));
        fq.push_back(frame_header);
        fq.push_back(8'($urandom_range(0, 255)));
        fq.push_back(lenb);
        if (lenb <= MAX_PAYLOAD) begin
            repeat (lenb) fq.push_back(8'($urandom_range(0, 255)));
            sum = '0;
            foreach (fq[i]) sum = sum ^ fq[i];
            if ($urandom_range(0, 3) == 0) fq.push_back(8'($urandom_range(0, 255)));
            else fq.push_back(sum);
        end
        if ($urandom_range(0, 15) == 0) begin
            cut = $urandom_range(1, fq.size() - 1);
            while (fq.size() > cut) void'(fq.pop_back());
        end
        foreach (fq[i]) push_byte(fq[i], 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(50, 400);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: begin
                i_out_stall <= 1'b0;
            end
            1: begin
                i_out_stall <= 1'($urandom_range(0, 1));
            end
            default: begin
                if (stall_run > 0) begin
                    stall_run--;
                    i_out_stall <= 1'b1;
                end else if ($urandom_range(0, 7) == 0) begin
                    stall_run = $urandom_range(1, 16);
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_frames.size() == 0) begin
                $error("result beat with no frame pending");
                errors++;
            end else begin
                oldest_frame = expected_frames.pop_front();
                if (o_command !== oldest_frame.command) begin
                    $error("command: expected %0h, actual %0h",
                           oldest_frame.command, o_command);
                    errors++;
                end
                if (o_payload_length !== oldest_frame.payload_length) begin
                    $error("payload_length: expected %0d, actual %0d",
                           oldest_frame.payload_length, o_payload_length);
                    errors++;
                end
                if (o_payload !== oldest_frame.payload) begin
                    $error("payload: expected %016h, actual %016h",
                           oldest_frame.payload, o_payload);
                    errors++;
                end
                if (o_checksum_ok !== oldest_frame.checksum_ok) begin
                    $error("checksum_ok: expected %0b, actual %0b",
                           oldest_frame.checksum_ok, o_checksum_ok);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [BYTE_W-1:0] headers [5];
        clear_frame_state();
        headers[0] = 8'h00;
        headers[1] = 8'hFF;
        headers[2] = 8'($urandom_range(1, 254));
        headers[3] = 8'($urandom_range(1, 254));
        headers[4] = 8'hAA;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (DIRECTED[i]) push_byte(DIRECTED[i].rx, DIRECTED[i].has_want, DIRECTED[i].want);
        foreach (headers[p]) begin
            write_header(headers[p]);
            items_sent = 0;
            while (items_sent < PHASE_ITEMS) send_random_frame();
        end
        drain_results();
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/xcfp_pkg.sv
hdl/xcfp_parse.sv
hdl/xcfp_out_stage.sv
hdl/xor_checked_frame_parser_core.sv
bench/xor_checked_frame_parser_core_test.sv
